@@ sv/frpc_pkg.sv @@
// Types and constants shared by the framed packet receiver checker.
package frpc_pkg;

  localparam int unsigned MAX_WORDS = 64;
  localparam int unsigned IDX_W     = 7;

  localparam logic [7:0]  END_BYTE  = 8'hFF;
  localparam logic [15:0] SEQ_TOP   = 16'hFFFF;
  localparam logic [16:0] SEQ_SPAN  = 17'h10000;

  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_WORDS);

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_LOST       = 3'd1;
  localparam logic [2:0] ST_LONG       = 3'd2;
  localparam logic [2:0] ST_DATA_FTR   = 3'd3;
  localparam logic [2:0] ST_LOST_FTR   = 3'd4;
  localparam logic [2:0] ST_LONG_FTR   = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       footer_mark;
    logic       frame_valid;
  } in_beat_t;

  typedef struct packed {
    logic        ack_level;
    logic        packet_done;
    logic [2:0]  status;
    logic [15:0] sequence_res;
    logic [31:0] good_total;
    logic [31:0] miss_total;
    logic [31:0] error_total;
  } out_beat_t;

endpackage

@@ sv/frpc_core.sv @@
// Packet framing state, sequence check and counters, one input beat per cycle while take is high.
module frpc_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  frpc_pkg::in_beat_t beat,
  output frpc_pkg::out_beat_t res
);
  import frpc_pkg::*;

  logic             in_packet, in_packet_next;
  logic             footer_seen, footer_seen_next;
  logic [IDX_W-1:0] word_index, word_index_next;
  logic [7:0]       seq_low_byte, seq_low_byte_next;
  logic [7:0]       seq_high_byte, seq_high_byte_next;
  logic [15:0]      previous_sequence, previous_sequence_next;
  logic             ack_state, ack_state_next;
  logic [31:0]      good_count, good_count_next;
  logic [31:0]      miss_count, miss_count_next;
  logic [31:0]      error_count, error_count_next;

  logic             active, done;
  logic [2:0]       code;
  logic [IDX_W-1:0] idx;
  logic             fseen;
  logic [15:0]      seq;
  logic [16:0]      gap;
  logic             follows;

  always_comb begin
    in_packet_next         = in_packet;
    footer_seen_next       = footer_seen;
    word_index_next        = word_index;
    seq_low_byte_next      = seq_low_byte;
    seq_high_byte_next     = seq_high_byte;
    previous_sequence_next = previous_sequence;
    ack_state_next         = ack_state;
    good_count_next        = good_count;
    miss_count_next        = miss_count;
    error_count_next       = error_count;
    done                   = 1'b0;
    code                   = ST_OK;

    active = in_packet || beat.frame_valid;
    idx    = in_packet ? word_index : '0;
    fseen  = in_packet ? footer_seen : 1'b0;

    if (active) begin
      footer_seen_next = fseen;
      word_index_next  = idx;
      if (idx == IDX_W'(1)) begin
        seq_low_byte_next = beat.data_byte;
      end else if (idx == IDX_W'(2)) begin
        seq_high_byte_next = beat.data_byte;
      end
      if (!beat.frame_valid) begin
        done = 1'b1;
        code = fseen ? ST_LOST_FTR : ST_LOST;
      end else begin
        ack_state_next = !ack_state;
        if (fseen) begin
          if (!beat.footer_mark) begin
            done = 1'b1;
            code = ST_DATA_FTR;
          end else if (beat.data_byte == END_BYTE) begin
            done = 1'b1;
            code = ST_OK;
          end
        end else begin
          footer_seen_next = beat.footer_mark;
        end
        if (!done) begin
          word_index_next = idx + IDX_W'(1);
          if (word_index_next >= MAX_IDX) begin
            done = 1'b1;
            code = footer_seen_next ? ST_LONG_FTR : ST_LONG;
          end
        end
      end
      in_packet_next = !done;
    end

    seq     = {seq_high_byte_next, seq_low_byte_next};
    follows = (seq == previous_sequence + 16'd1) ||
              ((seq == 16'd0) && (previous_sequence == SEQ_TOP));
    gap     = {1'b0, seq} - {1'b0, previous_sequence};
    gap     = (seq > previous_sequence) ? gap + 17'd1 : gap + SEQ_SPAN;

    if (done) begin
      if (code != ST_OK) begin
        error_count_next = error_count + 32'd1;
      end else if (!follows) begin
        miss_count_next = miss_count + {15'd0, gap};
      end else begin
        good_count_next = good_count + 32'd1;
      end
      previous_sequence_next = seq;
    end

    res.ack_level    = ack_state_next;
    res.packet_done  = done;
    res.status       = done ? code : ST_OK;
    res.sequence_res = seq;
    res.good_total   = good_count_next;
    res.miss_total   = miss_count_next;
    res.error_total  = error_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet         <= 1'b0;
      footer_seen       <= 1'b0;
      word_index        <= '0;
      seq_low_byte      <= '0;
      seq_high_byte     <= '0;
      previous_sequence <= '0;
      ack_state         <= 1'b0;
      good_count        <= '0;
      miss_count        <= '0;
      error_count       <= '0;
    end else if (take) begin
      in_packet         <= in_packet_next;
      footer_seen       <= footer_seen_next;
      word_index        <= word_index_next;
      seq_low_byte      <= seq_low_byte_next;
      seq_high_byte     <= seq_high_byte_next;
      previous_sequence <= previous_sequence_next;
      ack_state         <= ack_state_next;
      good_count        <= good_count_next;
      miss_count        <= miss_count_next;
      error_count       <= error_count_next;
    end
  end

endmodule

@@ sv/frpc_outbuf.sv @@
// Result register with skid stage between the core and the output channel.
module frpc_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_stall,
  input  frpc_pkg::out_beat_t push_data,
  output logic                valid,
  input  logic                stall,
  output frpc_pkg::out_beat_t data
);
  import frpc_pkg::*;

  logic      skid_valid;
  out_beat_t skid_data;
  logic      push, pop;

  assign push_stall = skid_valid;
  assign push       = push_valid && !skid_valid;
  assign pop        = valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!valid || pop) begin
      if (skid_valid) begin
        valid      <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!valid || pop) begin
      if (skid_valid) begin
        data <= skid_data;
      end else if (push) begin
        data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

@@ sv/framed_packet_receiver_checker.sv @@
// Top level of the framed packet receiver checker.
// Input channel: one sampled bus word per beat (data byte, footer mark, frame
// valid) on in_valid / in_stall / in_data. Output channel: one result beat for
// every input beat on out_valid / out_stall / out_data, carrying the ack level,
// packet end flag, status, sequence number and the good, miss and error totals.
// Each result is registered in the result register, or in the skid stage when
// the output stalls. Throughput: one beat per cycle while in_stall is low; the
// framing state and counters update from the registered state and incoming word.
// Reset (rst, synchronous, active high) returns the block to idle with all
// counters, sequence bytes and the ack level at zero, and empties the output.
// When the receiver stalls, the result register holds its beat and one more
// beat is taken into the skid stage; in_stall then rises until the output
// drains. Frame-less words while idle still yield a result with no change.
module framed_packet_receiver_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  frpc_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output frpc_pkg::out_beat_t out_data
);
  import frpc_pkg::*;

  out_beat_t res;
  logic      take;

  assign take = in_valid && !in_stall;

  frpc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .beat (in_data),
    .res  (res)
  );

  frpc_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_data  (res),
    .valid      (out_valid),
    .stall      (out_stall),
    .data       (out_data)
  );

endmodule

@@ tb/framed_packet_receiver_checker_tb.sv @@
`timescale 1ns / 100ps
// Testbench for the framed packet receiver checker: packet traffic in, every result beat checked.
module framed_packet_receiver_checker_tb;
  import frpc_pkg::*;

  class packet_check_model;
    logic        busy;
    logic        in_footer;
    logic        ack;
    logic [6:0]  word_idx;
    logic [7:0]  seq_lo;
    logic [7:0]  seq_hi;
    logic [15:0] prev_seq;
    logic [31:0] good_n;
    logic [31:0] miss_n;
    logic [31:0] err_n;
    out_beat_t   awaited_results[$];
    int          mismatches;
    int          words_n;
    int          checked_n;
    int          closed_n;
    int          endings[6];

    function new();
      busy      = 1'b0;
      in_footer = 1'b0;
      ack       = 1'b0;
      word_idx  = '0;
      seq_lo    = '0;
      seq_hi    = '0;
      prev_seq  = '0;
      good_n    = '0;
      miss_n    = '0;
      err_n     = '0;
    endfunction

    task report(string msg);
      if (mismatches < 50) begin
        $display("mismatch: %s", msg);
      end
      mismatches++;
    endtask

    function void take_word(in_beat_t w);
      out_beat_t   e;
      logic        done;
      logic [2:0]  code;
      logic [15:0] seq;
      done = 1'b0;
      code = ST_OK;
      words_n++;
      if (!busy && w.frame_valid) begin
        busy      = 1'b1;
        in_footer = 1'b0;
        word_idx  = '0;
      end
      if (busy) begin
        if (word_idx == 7'd1) begin
          seq_lo = w.data_byte;
        end else if (word_idx == 7'd2) begin
          seq_hi = w.data_byte;
        end
        if (!w.frame_valid) begin
          done = 1'b1;
          code = in_footer ? ST_LOST_FTR : ST_LOST;
        end else begin
          ack = ~ack;
          if (in_footer) begin
            if (!w.footer_mark) begin
              done = 1'b1;
              code = ST_DATA_FTR;
            end else if (w.data_byte == END_BYTE) begin
              done = 1'b1;
            end
          end else begin
            in_footer = w.footer_mark;
          end
          if (!done) begin
            word_idx = word_idx + 7'd1;
            if (word_idx >= MAX_IDX) begin
              done = 1'b1;
              code = in_footer ? ST_LONG_FTR : ST_LONG;
            end
          end
        end
        if (done) begin
          seq  = {seq_hi, seq_lo};
          busy = 1'b0;
          if (code != ST_OK) begin
            err_n++;
          end else if (({16'd0, seq} == {16'd0, prev_seq} + 32'd1)
                       || (seq == 16'd0 && prev_seq == SEQ_TOP)) begin
            good_n++;
          end else if (seq > prev_seq) begin
            miss_n += {16'd0, seq} - {16'd0, prev_seq} + 32'd1;
          end else begin
            miss_n += {16'd0, seq} + {16'd0, SEQ_TOP} - {16'd0, prev_seq} + 32'd1;
          end
          prev_seq = seq;
          closed_n++;
          endings[code]++;
        end
      end
      e.ack_level    = ack;
      e.packet_done  = done;
      e.status       = done ? code : ST_OK;
      e.sequence_res = {seq_hi, seq_lo};
      e.good_total   = good_n;
      e.miss_total   = miss_n;
      e.error_total  = err_n;
      awaited_results.push_back(e);
    endfunction

    task match_result(out_beat_t r);
      out_beat_t e;
      if (awaited_results.size() == 0) begin
        report($sformatf("result beat with nothing outstanding"));
        return;
      end
      e = awaited_results.pop_front();
      if (r.ack_level !== e.ack_level)
        report($sformatf("beat %0d ack_level %0h, want %0h", checked_n, r.ack_level,
                         e.ack_level));
      if (r.packet_done !== e.packet_done)
        report($sformatf("beat %0d packet_done %0h, want %0h", checked_n, r.packet_done,
                         e.packet_done));
      if (r.status !== e.status)
        report($sformatf("beat %0d status %0d, want %0d", checked_n, r.status, e.status));
      if (r.sequence_res !== e.sequence_res)
        report($sformatf("beat %0d sequence_res %h, want %h", checked_n, r.sequence_res,
                         e.sequence_res));
      if (r.good_total !== e.good_total)
        report($sformatf("beat %0d good_total %0d, want %0d", checked_n, r.good_total,
                         e.good_total));
      if (r.miss_total !== e.miss_total)
        report($sformatf("beat %0d miss_total %0d, want %0d", checked_n, r.miss_total,
                         e.miss_total));
      if (r.error_total !== e.error_total)
        report($sformatf("beat %0d error_total %0d, want %0d", checked_n, r.error_total,
                         e.error_total));
      checked_n++;
    endtask
  endclass

  localparam int RAND_WORDS  = 650;
  localparam int CYCLE_LIMIT = 200000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  packet_check_model rx_model;
  in_beat_t          pkt_words[$];
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                fed_words = 0;
  int unsigned       cycle_n = 0;

  framed_packet_receiver_checker i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_n);
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (!rst && out_valid && !out_stall) begin
      rx_model.match_result(out_data);
    end
  end

  task automatic send_word(input in_beat_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rx_model.take_word(w);
  endtask

  task automatic send_packet();
    foreach (pkt_words[i]) send_word(pkt_words[i]);
    fed_words += pkt_words.size();
  endtask

  // head words before the footer, tail footer words between its first word and the end byte
  function automatic void make_packet(logic [15:0] seq, int head, int tail);
    in_beat_t w;
    pkt_words.delete();
    for (int i = 0; i < head + tail + 2; i++) begin
      w.frame_valid = 1'b1;
      w.footer_mark = (i >= head);
      if (i == head + tail + 1) w.data_byte = END_BYTE;
      else if (i == 1) w.data_byte = seq[7:0];
      else if (i == 2) w.data_byte = seq[15:8];
      else if (i > head) w.data_byte = 8'($urandom_range(254));
      else w.data_byte = 8'($urandom);
      pkt_words.push_back(w);
    end
  endfunction

  function automatic void cut_after(int k);
    while (pkt_words.size() > k + 1) void'(pkt_words.pop_back());
  endfunction

  function automatic void drop_frame(int k);
    pkt_words[k].frame_valid = 1'b0;
    pkt_words[k].footer_mark = 1'($urandom);
    cut_after(k);
  endfunction

  function automatic void clear_mark(int k);
    pkt_words[k].footer_mark = 1'b0;
    cut_after(k);
  endfunction

  initial begin
    int          head;
    int          tail;
    int          kind;
    int          ph;
    logic [15:0] seq;
    rx_model = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_word('{data_byte: 8'hFF, footer_mark: 1'b1, frame_valid: 1'b0});
    make_packet(16'h0001, 2, 0);
    send_packet();
    make_packet(SEQ_TOP, 2, 0);
    send_packet();
    make_packet(16'h0000, 2, 0);
    send_packet();
    make_packet(16'h1234, 3, 0);
    drop_frame(1);
    send_packet();
    make_packet(16'h00FF, 0, 2);
    clear_mark(1);
    send_packet();
    make_packet(16'hFF00, 0, 2);
    drop_frame(2);
    send_packet();
    make_packet(rx_model.prev_seq, 2, 0);
    send_packet();

    fed_words = 0;
    while (fed_words < RAND_WORDS) begin
      ph = (fed_words * 8 / RAND_WORDS) % 4;
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 52;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 52;
        end
        default: begin
          idle_pct  = 24;
          stall_pct = 24;
        end
      endcase

      kind = $urandom_range(99);
      if (kind < 60) seq = rx_model.prev_seq + 16'd1;
      else if (kind < 70) seq = rx_model.prev_seq;
      else if (kind < 80) seq = (rx_model.prev_seq == SEQ_TOP) ? 16'd0 : SEQ_TOP;
      else seq = 16'($urandom);

      kind = $urandom_range(99);
      if (kind < 3) begin
        head = $urandom_range(80);
        tail = (head > 63) ? 0 : 63 - head;
        make_packet(seq, head, tail);
        cut_after(MAX_WORDS - 1);
      end else begin
        if ($urandom_range(9) == 0) begin
          head = $urandom_range(40);
          tail = $urandom_range(20);
        end else begin
          head = $urandom_range(6);
          tail = $urandom_range(3);
        end
        make_packet(seq, head, tail);
        kind = $urandom_range(99);
        if (kind < 12) drop_frame($urandom_range(pkt_words.size() - 1, 1));
        else if (kind < 22) clear_mark($urandom_range(pkt_words.size() - 1, head + 1));
      end
      send_packet();

      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(3, 1)) begin
          send_word('{data_byte: 8'($urandom), footer_mark: 1'($urandom), frame_valid: 1'b0});
        end
      end
    end

    in_valid <= 1'b0;
    while (rx_model.awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d bus words accepted, %0d result beats compared, %0d packets closed",
             rx_model.words_n, rx_model.checked_n, rx_model.closed_n);
    $display("endings: ok %0d, lost %0d, long %0d, footer data %0d, footer lost %0d, %s %0d",
             rx_model.endings[ST_OK], rx_model.endings[ST_LOST], rx_model.endings[ST_LONG],
             rx_model.endings[ST_DATA_FTR], rx_model.endings[ST_LOST_FTR], "footer long",
             rx_model.endings[ST_LONG_FTR]);
    if (rx_model.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/frpc_pkg.sv
sv/frpc_core.sv
sv/frpc_outbuf.sv
sv/framed_packet_receiver_checker.sv
tb/framed_packet_receiver_checker_tb.sv
